// ===== design/node_id_address_check_assert.svh =====
// Assertion macros shared by the node identifier checker.
// Needs clk and rst_n in the scope of each use.
`ifndef NODE_ID_ADDRESS_CHECK_ASSERT_SVH
`define NODE_ID_ADDRESS_CHECK_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define NIC_ASSERT_SAME(lbl, pre, post) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
    else $error("nic assertion failed");

// The consequent must hold in the cycle after the antecedent.
`define NIC_ASSERT_NEXT(lbl, pre, post) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
    else $error("nic assertion failed");

`endif

// ===== design/nic_pkg.sv =====
// Types, constants and CRC-32C helpers for the node identifier checker.
// No dependencies.
package nic_pkg;

  localparam logic [1:0] FAM_NONE = 2'd0;
  localparam logic [1:0] FAM_V4   = 2'd1;
  localparam logic [1:0] FAM_V6   = 2'd2;

  localparam int unsigned NUM_OCTETS = 8;
  localparam int unsigned V4_OCTETS  = 4;

  localparam logic [31:0] CRC_POLY    = 32'h82F6_3B78;
  localparam logic [31:0] CRC_INIT    = 32'hFFFF_FFFF;
  localparam logic [23:0] PREFIX_MASK = 24'hFF_FFF8;
  localparam logic [2:0]  SEED_MASK   = 3'h7;

  typedef struct packed {
    logic [1:0]  addr_family;
    logic [63:0] addr_octets;
    logic        addr_public;
    logic [23:0] id_head;
    logic [7:0]  id_seed;
  } in_t;

  typedef struct packed {
    logic [23:0] expected_prefix;
    logic        checked;
    logic        accepted;
  } out_t;

  // Word carried from cell to cell along with the running CRC.
  typedef struct packed {
    logic [1:0]  family;
    logic [63:0] octets;
    logic        is_public;
    logic [23:0] head;
    logic [2:0]  seed;
    logic [31:0] crc;
  } stage_t;

  function automatic logic [7:0] octet_mask(input logic [1:0] family,
                                            input logic [2:0] idx);
    logic [7:0] m;
    m = 8'h00;
    case (family)
      FAM_V4: begin
        case (idx)
          3'd0:    m = 8'h03;
          3'd1:    m = 8'h0f;
          3'd2:    m = 8'h3f;
          3'd3:    m = 8'hff;
          default: m = 8'h00;
        endcase
      end
      FAM_V6:  m = 8'hff >> (3'd7 - idx);
      default: m = 8'h00;
    endcase
    return m;
  endfunction

  // Reflected CRC-32C update over one octet.
  function automatic logic [31:0] crc_byte(input logic [31:0] crc_in,
                                           input logic [7:0]  b);
    logic [31:0] c;
    c = crc_in ^ {24'h0, b};
    for (int k = 0; k < 8; k++) begin
      c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
    end
    return c;
  endfunction

endpackage

// ===== design/nic_crc_cell.sv =====
// One CRC cell: folds its octet into the CRC if the family uses it, registers the word.
// Depends on nic_pkg.
module nic_crc_cell #(
  parameter int unsigned IDX = 0
) (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            up_valid,
  input  nic_pkg::stage_t up_word,
  output logic            up_stall,
  output logic            dn_valid,
  output nic_pkg::stage_t dn_word,
  input  logic            dn_stall
);

  localparam int unsigned HI = 63 - 8 * IDX;

  logic            valid_r;
  nic_pkg::stage_t word_r;
  nic_pkg::stage_t word_nxt;
  logic            adv;
  logic            active;
  logic [7:0]      octet;

  assign adv      = !valid_r || !dn_stall;
  assign up_stall = !adv;

  assign active = (up_word.family == nic_pkg::FAM_V6) ||
                  ((up_word.family == nic_pkg::FAM_V4) && (IDX < nic_pkg::V4_OCTETS));

  always_comb begin
    octet = up_word.octets[HI -: 8] & nic_pkg::octet_mask(up_word.family, 3'(IDX));
    // The seed bits sit in the top three bits of the leading octet.
    if (IDX == 0) begin
      octet = octet | {up_word.seed & nic_pkg::SEED_MASK, 5'b0};
    end
    word_nxt = up_word;
    if (active) begin
      word_nxt.crc = nic_pkg::crc_byte(up_word.crc, octet);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (adv) begin
      valid_r <= up_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv && up_valid) begin
      word_r <= word_nxt;
    end
  end

  assign dn_valid = valid_r;
  assign dn_word  = word_r;

endmodule

// ===== design/nic_result.sv =====
// Final stage: finishes the CRC, forms the prefix and the verdict, holds the output word.
// Depends on nic_pkg.
module nic_result (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            up_valid,
  input  nic_pkg::stage_t up_word,
  output logic            up_stall,
  output logic            out_valid,
  output nic_pkg::out_t   out_word,
  input  logic            out_stall
);

  logic          valid_r;
  nic_pkg::out_t word_r;
  nic_pkg::out_t word_nxt;
  logic          adv;
  logic          known;
  logic [31:0]   crc_fin;

  assign adv      = !valid_r || !out_stall;
  assign up_stall = !adv;

  always_comb begin
    known   = (up_word.family == nic_pkg::FAM_V4) || (up_word.family == nic_pkg::FAM_V6);
    crc_fin = up_word.crc ^ nic_pkg::CRC_INIT;
    word_nxt.expected_prefix = known ? (crc_fin[31:8] & nic_pkg::PREFIX_MASK) : 24'h0;
    word_nxt.checked  = known && up_word.is_public;
    word_nxt.accepted = !word_nxt.checked ||
                        ((up_word.head & nic_pkg::PREFIX_MASK) == word_nxt.expected_prefix);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (adv) begin
      valid_r <= up_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv && up_valid) begin
      word_r <= word_nxt;
    end
  end

  assign out_valid = valid_r;
  assign out_word  = word_r;

endmodule

// ===== design/node_id_address_check.sv =====
// Node identifier check: an accepted word is registered in one CRC cell per address octet
// and then in the result register. Throughput is one word per cycle while out_stall is low;
// each cell and the result stage stall on their own.
// Synchronous active-low reset empties every stage; payload registers are not reset.
// Depends on nic_pkg, nic_crc_cell, nic_result and the assertion header.
`include "node_id_address_check_assert.svh"

module node_id_address_check (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  input  nic_pkg::in_t  in_word,
  output logic          in_stall,
  output logic          out_valid,
  output nic_pkg::out_t out_word,
  input  logic          out_stall
);

  localparam int unsigned N = nic_pkg::NUM_OCTETS;

  nic_pkg::stage_t st  [0:N];
  logic            vld [0:N];
  logic            stl [0:N];

  always_comb begin
    st[0].family    = in_word.addr_family;
    st[0].octets    = in_word.addr_octets;
    st[0].is_public = in_word.addr_public;
    st[0].head      = in_word.id_head;
    st[0].seed      = in_word.id_seed[2:0];
    st[0].crc       = nic_pkg::CRC_INIT;
  end
  assign vld[0]   = in_valid;
  assign in_stall = stl[0];

  for (genvar i = 0; i < N; i++) begin : g_cell
    nic_crc_cell #(.IDX(i)) u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .up_valid (vld[i]),
      .up_word  (st[i]),
      .up_stall (stl[i]),
      .dn_valid (vld[i+1]),
      .dn_word  (st[i+1]),
      .dn_stall (stl[i+1])
    );
  end

  nic_result u_result (
    .clk       (clk),
    .rst_n     (rst_n),
    .up_valid  (vld[N]),
    .up_word   (st[N]),
    .up_stall  (stl[N]),
    .out_valid (out_valid),
    .out_word  (out_word),
    .out_stall (out_stall)
  );

  `NIC_ASSERT_SAME(a_skip_accepts, out_valid && !out_word.checked, out_word.accepted)
  `NIC_ASSERT_SAME(a_prefix_low_clear, out_valid, out_word.expected_prefix[2:0] == 3'b000)
  `NIC_ASSERT_NEXT(a_first_cell_loads, in_valid && !in_stall, vld[1])

endmodule

// ===== tb/sv/testbench.sv =====
// Self-checking testbench for node_id_address_check, the address-derived node identifier check.
// Depends on nic_pkg and the node_id_address_check RTL; it predicts every result on its own.
`timescale 1ns / 100ps

module testbench;

  localparam logic [1:0] FAM_RESERVED   = 2'd3;
  localparam int         RANDOM_PER_RUN = 611;
  localparam int         WATCHDOG_LIMIT = 2000;
  localparam int         DRAIN_CYCLES   = 20;

  logic          clk = 1'b0;
  logic          rst_n = 1'b0;
  logic          in_valid = 1'b0;
  nic_pkg::in_t  in_word = '0;
  logic          in_stall;
  logic          out_valid;
  nic_pkg::out_t out_word;
  logic          out_stall = 1'b0;

  nic_pkg::in_t  pending_words[$];
  nic_pkg::out_t verdicts_due[$];
  int   send_idle_pct = 0;
  int   recv_stall_pct = 0;
  int   mismatches = 0;
  int   quiet_cycles = 0;

  node_id_address_check dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_word   (in_word),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_word  (out_word),
    .out_stall (out_stall)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // Prefix derived from the masked address octets and the three low seed bits.
  function automatic logic [23:0] address_prefix(nic_pkg::in_t w);
    logic [31:0] crc;
    logic [7:0]  oct;
    int          count;
    count = (w.addr_family == nic_pkg::FAM_V4) ? 4 : 8;
    crc = nic_pkg::CRC_INIT;
    for (int i = 0; i < count; i++) begin
      oct = w.addr_octets[63 - 8 * i -: 8];
      // IPv4 masks keep 2, 4, 6, 8 bits; IPv6 masks keep 1 through 8 bits.
      if (w.addr_family == nic_pkg::FAM_V4) oct &= 8'((1 << (2 * i + 2)) - 1);
      else oct &= 8'((1 << (i + 1)) - 1);
      if (i == 0) oct |= {w.id_seed[2:0], 5'b0};
      crc ^= {24'h0, oct};
      for (int b = 0; b < 8; b++) begin
        crc = (crc >> 1) ^ (nic_pkg::CRC_POLY & {32{crc[0]}});
      end
    end
    crc = ~crc;
    return crc[31:8] & nic_pkg::PREFIX_MASK;
  endfunction

  function automatic nic_pkg::out_t predict_verdict(nic_pkg::in_t w);
    nic_pkg::out_t r;
    logic known;
    known = (w.addr_family == nic_pkg::FAM_V4) || (w.addr_family == nic_pkg::FAM_V6);
    r.expected_prefix = known ? address_prefix(w) : 24'h0;
    r.checked = known && w.addr_public;
    r.accepted = r.checked ? ((w.id_head & nic_pkg::PREFIX_MASK) == r.expected_prefix) : 1'b1;
    return r;
  endfunction

  function automatic nic_pkg::in_t word_of(logic [1:0] fam, logic [63:0] octets, logic pub,
                                           logic [23:0] head, logic [7:0] seed);
    nic_pkg::in_t w;
    w.addr_family = fam;
    w.addr_octets = octets;
    w.addr_public = pub;
    w.id_head = head;
    w.id_seed = seed;
    return w;
  endfunction

  function automatic nic_pkg::in_t matched(nic_pkg::in_t w);
    w.id_head = address_prefix(w) | 24'($urandom_range(7));
    return w;
  endfunction

  // A single wrong bit inside the compared 21 bits.
  function automatic nic_pkg::in_t near_miss(nic_pkg::in_t w);
    w = matched(w);
    w.id_head ^= 24'h1 << $urandom_range(23, 3);
    return w;
  endfunction

  function automatic nic_pkg::in_t random_word();
    nic_pkg::in_t w;
    int  roll;
    roll = $urandom_range(99);
    w = word_of(FAM_RESERVED, {$urandom, $urandom}, ($urandom_range(7) != 0),
                24'($urandom), 8'($urandom));
    if (roll < 42) w.addr_family = nic_pkg::FAM_V4;
    else if (roll < 84) w.addr_family = nic_pkg::FAM_V6;
    else if (roll < 92) w.addr_family = nic_pkg::FAM_NONE;
    roll = $urandom_range(99);
    if (roll < 45) w = matched(w);
    else if (roll < 65) w = near_miss(w);
    return w;
  endfunction

  always @(posedge clk) begin : drive_words
    logic hold_off;
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else if (!in_valid || !in_stall) begin
      if (in_valid) verdicts_due.push_back(predict_verdict(in_word));
      hold_off = ($urandom_range(99) < send_idle_pct);
      if (pending_words.size() != 0 && !hold_off) begin
        in_word <= pending_words.pop_front();
        in_valid <= 1'b1;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  always @(posedge clk) begin : check_results
    nic_pkg::out_t want;
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        if (verdicts_due.size() == 0) begin
          $display("%0t: unexpected result word, expected none, actual %h", $time, out_word);
          mismatches++;
        end else begin
          want = verdicts_due.pop_front();
          if (out_word.expected_prefix !== want.expected_prefix) begin
            $display("%0t: expected_prefix mismatch, expected %h, actual %h", $time,
                     want.expected_prefix, out_word.expected_prefix);
            mismatches++;
          end
          if (out_word.checked !== want.checked) begin
            $display("%0t: checked mismatch, expected %b, actual %b", $time,
                     want.checked, out_word.checked);
            mismatches++;
          end
          if (out_word.accepted !== want.accepted) begin
            $display("%0t: accepted mismatch, expected %b, actual %b", $time,
                     want.accepted, out_word.accepted);
            mismatches++;
          end
        end
      end
      out_stall <= ($urandom_range(99) < recv_stall_pct);
    end
  end

  always @(posedge clk) begin : watchdog
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("*** FAILED ***");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin : run_phases
    logic [63:0] ones;
    logic [63:0] v4_addr;
    ones = '1;
    v4_addr = {32'hC0A8_2A17, 32'h0};
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;

    @(negedge clk);
    send_idle_pct <= 8;
    recv_stall_pct <= 85;
    // Directed words: unspecified and reserved families, field extremes, ignored
    // IPv4 octets, ignored seed and identifier bits, matches and near misses.
    pending_words.push_back(word_of(nic_pkg::FAM_NONE, ones, 1'b1, 24'hFF_FFFF, 8'hFF));
    pending_words.push_back(word_of(FAM_RESERVED, ones, 1'b1, 24'h0, 8'h07));
    pending_words.push_back(word_of(nic_pkg::FAM_V4, 64'h0, 1'b1, 24'h0, 8'h00));
    pending_words.push_back(matched(word_of(nic_pkg::FAM_V4, 64'h0, 1'b1, 24'h0, 8'h00)));
    pending_words.push_back(matched(word_of(nic_pkg::FAM_V4, ones, 1'b1, 24'h0, 8'hFF)));
    pending_words.push_back(matched(word_of(nic_pkg::FAM_V4, v4_addr | 64'hFFFF_FFFF, 1'b1,
                                            24'h0, 8'h05)));
    pending_words.push_back(matched(word_of(nic_pkg::FAM_V4, v4_addr, 1'b1, 24'h0, 8'h05)));
    pending_words.push_back(matched(word_of(nic_pkg::FAM_V4, v4_addr, 1'b1, 24'h0, 8'hF8)));
    pending_words.push_back(near_miss(word_of(nic_pkg::FAM_V4, v4_addr, 1'b1, 24'h0, 8'h02)));
    pending_words.push_back(word_of(nic_pkg::FAM_V4, ones, 1'b1, address_prefix(
        word_of(nic_pkg::FAM_V4, ones, 1'b1, 24'h0, 8'h03)) | 24'h7, 8'h03));
    pending_words.push_back(matched(word_of(nic_pkg::FAM_V6, 64'h0, 1'b1, 24'h0, 8'h00)));
    pending_words.push_back(matched(word_of(nic_pkg::FAM_V6, ones, 1'b1, 24'h0, 8'h07)));
    pending_words.push_back(matched(word_of(nic_pkg::FAM_V6, ones, 1'b1, 24'h0, 8'hFF)) ^ {
        2'b0, 64'h0, 1'b0, 24'h00_0008, 8'h0});
    pending_words.push_back(matched(word_of(nic_pkg::FAM_V6, ones, 1'b1, 24'h0, 8'hFF)) ^ {
        2'b0, 64'h0, 1'b0, 24'h80_0000, 8'h0});
    pending_words.push_back(word_of(nic_pkg::FAM_V6, 64'h2001_0DB8_85A3_0042, 1'b1, 24'h0,
                                    8'h01));
    pending_words.push_back(word_of(nic_pkg::FAM_V4, ones, 1'b0, 24'hFF_FFFF, 8'hFF));
    pending_words.push_back(word_of(nic_pkg::FAM_V6, {$urandom, $urandom}, 1'b0, 24'h0,
                                    8'h00));
    pending_words.push_back(word_of(nic_pkg::FAM_NONE, 64'h0, 1'b0, 24'h0, 8'h00));
    for (int i = 0; i < RANDOM_PER_RUN; i++) pending_words.push_back(random_word());

    for (int phase = 1; phase < 3; phase++) begin
      // Let everything in flight come out before the idling pattern changes.
      while (pending_words.size() != 0 || in_valid || verdicts_due.size() != 0) begin
        @(negedge clk);
      end
      send_idle_pct <= (phase == 1) ? 85 : 0;
      recv_stall_pct <= (phase == 1) ? 8 : 0;
      @(negedge clk);
      for (int i = 0; i < RANDOM_PER_RUN; i++) pending_words.push_back(random_word());
    end

    while (pending_words.size() != 0 || in_valid || verdicts_due.size() != 0) begin
      @(negedge clk);
    end
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
